### hdl/population_fitness_statistics_core_assert.svh
// Assertion macros used by the statistics core controller.
`ifndef POPULATION_FITNESS_STATISTICS_CORE_ASSERT_SVH
`define POPULATION_FITNESS_STATISTICS_CORE_ASSERT_SVH

// A condition that implies a consequence on the same edge.
`define PFS_ASSERT_IMPL(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("assertion failed");

// A condition that implies a consequence on the next edge.
`define PFS_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/pfs_pkg.sv
`timescale 1ns / 1ps
package pfs_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIV,
    ST_MSQ,
    ST_SQRT,
    ST_EMIT
  } pfs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;
    logic div_start;
    logic div_step;
    logic msq_load;
    logic sqrt_start;
    logic sqrt_step;
    logic emit;
  } pfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_member;
    logic div_done;
    logic sqrt_done;
  } pfs_sts_t;

  localparam int unsigned CfgWidth = 11;
  localparam int unsigned GenWidth = 16;

endpackage

### hdl/population_fitness_statistics_core.sv
`timescale 1ns / 1ps
// Per-generation fitness statistics. Each accepted value (start high, busy low)
// is added to the accumulators. After a generation's last member, busy is
// high through a load, two restoring dividers sharing a step counter that form
// 2*FITNESS_WIDTH+log2(MAX_POP)+1 quotient bits, a squared mean, a square root
// of (that+1)/2 bits rounded up, and a hand-off. The result appears once busy
// is low again, as result_valid_o pulses for exactly one cycle. The receiver
// cannot stall: the result must be taken in that cycle.
module population_fitness_statistics_core #(
  parameter int unsigned MAX_POP       = 1024,
  parameter int unsigned FITNESS_WIDTH = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfs_pkg::CfgWidth-1:0]       cfg_data_i,
  input  logic signed [FITNESS_WIDTH-1:0]    fitness_i,
  input  logic [pfs_pkg::GenWidth-1:0]       generation_i,
  output logic                               result_valid_o,
  output logic signed [FITNESS_WIDTH-1:0]    min_fitness_o,
  output logic signed [FITNESS_WIDTH-1:0]    max_fitness_o,
  output logic signed [FITNESS_WIDTH-1:0]    mean_fitness_o,
  output logic [FITNESS_WIDTH-2:0]           std_dev_o,
  output logic                               best_improved_o,
  output logic [$clog2(MAX_POP)-1:0]         best_index_o,
  output logic signed [FITNESS_WIDTH-1:0]    best_fitness_o,
  output logic [pfs_pkg::GenWidth-1:0]       best_generation_o
);
  import pfs_pkg::*;

  localparam logic [CfgWidth-1:0] PopReset = CfgWidth'(1024);

  pfs_cmd_t cmd;
  pfs_sts_t sts;
  logic [CfgWidth-1:0] pop_q;

  // Population size register; every transfer is taken.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= PopReset;
    end else if (cfg_valid_i) begin
      pop_q <= cfg_data_i;
    end
  end

  pfs_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pfs_datapath #(
    .MaxPop   (MAX_POP),
    .FitWidth (FITNESS_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pop_size_i        (pop_q),
    .fitness_i         (fitness_i),
    .generation_i      (generation_i),
    .strobe_o          (result_valid_o),
    .min_fitness_o     (min_fitness_o),
    .max_fitness_o     (max_fitness_o),
    .mean_fitness_o    (mean_fitness_o),
    .std_dev_o         (std_dev_o),
    .best_improved_o   (best_improved_o),
    .best_index_o      (best_index_o),
    .best_fitness_o    (best_fitness_o),
    .best_generation_o (best_generation_o)
  );

endmodule

### hdl/pfs_datapath.sv
`timescale 1ns / 1ps
module pfs_datapath #(
  parameter int unsigned MaxPop   = 1024,
  parameter int unsigned FitWidth = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfs_pkg::pfs_cmd_t               cmd_i,
  output pfs_pkg::pfs_sts_t               sts_o,
  input  logic [pfs_pkg::CfgWidth-1:0]    pop_size_i,
  input  logic signed [FitWidth-1:0]      fitness_i,
  input  logic [pfs_pkg::GenWidth-1:0]    generation_i,
  output logic                            strobe_o,
  output logic signed [FitWidth-1:0]      min_fitness_o,
  output logic signed [FitWidth-1:0]      max_fitness_o,
  output logic signed [FitWidth-1:0]      mean_fitness_o,
  output logic [FitWidth-2:0]             std_dev_o,
  output logic                            best_improved_o,
  output logic [$clog2(MaxPop)-1:0]       best_index_o,
  output logic signed [FitWidth-1:0]      best_fitness_o,
  output logic [pfs_pkg::GenWidth-1:0]    best_generation_o
);
  import pfs_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxPop) + 1;
  localparam int unsigned IdxW  = $clog2(MaxPop);
  localparam int unsigned SumW  = FitWidth + CntW;
  localparam int unsigned SqW   = 2 * FitWidth + CntW;
  localparam int unsigned MagW  = SumW;
  localparam int unsigned DivW  = SqW;
  localparam int unsigned DivCW = $clog2(DivW + 1);
  localparam int unsigned SqrtW = SqW + 1;
  localparam int unsigned RootW = (SqrtW + 1) / 2;
  localparam int unsigned SqrtCW = $clog2(RootW + 1);
  localparam int unsigned FitMax = (1 << (FitWidth - 1)) - 1;

  logic signed [FitWidth-1:0] min_q, max_q, best_q;
  logic signed [SumW-1:0]     sum_q;
  logic [SqW-1:0]             sq_q;
  logic [CntW-1:0]            cnt_q, cnt_d, eff_n;
  logic [IdxW-1:0]            bidx_q;
  logic [GenWidth-1:0]        bgen_q;
  logic                       impr_q;
  logic [FitWidth-1:0]        mag_f;
  logic [2*FitWidth-1:0]      sq_f;

  // Effective population size: zero counts as one, saturate at the maximum.
  always_comb begin
    if (pop_size_i == '0) begin
      eff_n = CntW'(1);
    end else if (CntW'(pop_size_i) > CntW'(MaxPop) || (CntW < CfgWidth &&
                 (pop_size_i >> CntW) != '0)) begin
      eff_n = CntW'(MaxPop);
    end else begin
      eff_n = CntW'(pop_size_i);
    end
  end

  assign mag_f = fitness_i[FitWidth-1] ? FitWidth'(-fitness_i) : fitness_i;
  assign sq_f  = mag_f * mag_f;
  assign cnt_d = cnt_q + CntW'(1);
  assign sts_o.last_member = cmd_i.accum && (cnt_d >= eff_n);

  // Running accumulators and global best.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      cnt_q  <= '0;
      impr_q <= 1'b0;
      best_q <= FitWidth'(FitMax);
      bidx_q <= '0;
      bgen_q <= '0;
    end else if (cmd_i.accum) begin
      if (cnt_q == '0 || fitness_i < min_q) min_q <= fitness_i;
      if (cnt_q == '0 || fitness_i > max_q) max_q <= fitness_i;
      sum_q <= sum_q + SumW'(fitness_i);
      sq_q  <= sq_q + SqW'(sq_f);
      cnt_q <= cnt_d;
      if (fitness_i < best_q) begin
        best_q <= fitness_i;
        bidx_q <= IdxW'(cnt_q);
        bgen_q <= generation_i;
        impr_q <= 1'b1;
      end
    end else if (cmd_i.emit) begin
      sum_q  <= '0;
      sq_q   <= '0;
      cnt_q  <= '0;
      impr_q <= 1'b0;
    end
  end

  // Two restoring dividers share one step counter: |sum|/n and sumsq/n.
  logic [DivW-1:0]   qs_q, qq_q;
  logic [CntW:0]     rs_q, rq_q;
  logic [DivCW-1:0]  dcnt_q;
  logic              sneg_q;
  logic [CntW:0]     rs_t, rq_t;
  logic [MagW-1:0]   sabs;
  assign sabs = sum_q[SumW-1] ? MagW'(-sum_q) : MagW'(sum_q);
  assign rs_t = {rs_q[CntW-1:0], qs_q[DivW-1]};
  assign rq_t = {rq_q[CntW-1:0], qq_q[DivW-1]};
  assign sts_o.div_done = (dcnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DivCW'(DivW);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - DivCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      qs_q   <= DivW'(sabs);
      qq_q   <= sq_q;
      rs_q   <= '0;
      rq_q   <= '0;
      sneg_q <= sum_q[SumW-1];
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      if (rs_t >= {1'b0, cnt_q}) begin
        rs_q <= rs_t - {1'b0, cnt_q};
        qs_q <= {qs_q[DivW-2:0], 1'b1};
      end else begin
        rs_q <= rs_t;
        qs_q <= {qs_q[DivW-2:0], 1'b0};
      end
      if (rq_t >= {1'b0, cnt_q}) begin
        rq_q <= rq_t - {1'b0, cnt_q};
        qq_q <= {qq_q[DivW-2:0], 1'b1};
      end else begin
        rq_q <= rq_t;
        qq_q <= {qq_q[DivW-2:0], 1'b0};
      end
    end
  end

  // Mean magnitude squared, and the absolute difference to sumsq/n.
  logic [FitWidth-1:0] mean_mag;
  logic [SqrtW-1:0]    msq_q, diff_abs;
  assign mean_mag = FitWidth'(qs_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.msq_load) begin
      msq_q <= SqrtW'(mean_mag * mean_mag);
    end
  end
  always_comb begin
    if (SqrtW'(qq_q) >= msq_q) diff_abs = SqrtW'(qq_q) - msq_q;
    else diff_abs = msq_q - SqrtW'(qq_q);
  end

  // Digit-by-digit square root, one result bit per step.
  logic [SqrtW-1:0]  x_q;
  logic [RootW+1:0]  rem_q;
  logic [RootW-1:0]  root_q;
  logic [SqrtCW-1:0] scnt_q;
  logic [RootW+1:0]  rem_t, trial;
  assign rem_t = {rem_q[RootW-1:0], x_q[SqrtW-1:SqrtW-2]};
  assign trial = {root_q, 2'b01};
  assign sts_o.sqrt_done = (scnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      scnt_q <= SqrtCW'(RootW);
    end else if (cmd_i.sqrt_step && scnt_q != '0) begin
      scnt_q <= scnt_q - SqrtCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      x_q    <= (SqrtW % 2 == 1) ? (diff_abs << 1) : diff_abs;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step && scnt_q != '0) begin
      x_q <= x_q << 2;
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  // Result registers, flagged by a strobe that is high for one cycle.
  logic [FitWidth-1:0] mean_s;
  logic [FitWidth-2:0] sd_s;
  assign mean_s = sneg_q ? FitWidth'(-mean_mag) : mean_mag;
  assign sd_s = (RootW > FitWidth - 1 &&
                 (root_q >> (FitWidth - 1)) != '0) ? '1 : (FitWidth-1)'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      min_fitness_o     <= min_q;
      max_fitness_o     <= max_q;
      mean_fitness_o    <= mean_s;
      std_dev_o         <= sd_s;
      best_improved_o   <= impr_q;
      best_index_o      <= bidx_q;
      best_fitness_o    <= best_q;
      best_generation_o <= bgen_q;
    end
  end

endmodule

### hdl/pfs_controller.sv
`timescale 1ns / 1ps
module pfs_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pfs_pkg::pfs_sts_t sts_i,
  output pfs_pkg::pfs_cmd_t cmd_o
);
  import pfs_pkg::*;

  `include "population_fitness_statistics_core_assert.svh"

  pfs_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_ACCUM: begin
        busy = 1'b0;
        cmd_o.accum = start;
        if (start && sts_i.last_member) state_d = ST_LOAD;
      end
      // The last member is now in the accumulators, so the dividers can load.
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      // Step the dividers; once done, square the mean.
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.msq_load = 1'b1;
          state_d = ST_MSQ;
        end
      end
      // The squared mean is registered, so the root can take the difference.
      ST_MSQ: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  `PFS_ASSERT_IMPL(a_no_accum_busy, clk_i, rst_ni, busy, !cmd_o.accum)
  `PFS_ASSERT_NEXT(a_emit_to_idle, clk_i, rst_ni, cmd_o.emit, !busy)
  `PFS_ASSERT_NEXT(a_div_kick, clk_i, rst_ni, cmd_o.div_start, state_q == ST_DIV)

endmodule

### verif/pfs_stats_checker.sv
`timescale 1ns / 1ps
// Watches the value, size and result transfers of the statistics core,
// works out each generation's expected summary and compares it with the block.
module pfs_stats_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [pfs_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic signed [23:0]           fitness_i,
  input  logic [pfs_pkg::GenWidth-1:0] generation_i,
  input  logic                         result_valid_o,
  input  logic signed [23:0]           min_fitness_o,
  input  logic signed [23:0]           max_fitness_o,
  input  logic signed [23:0]           mean_fitness_o,
  input  logic [22:0]                  std_dev_o,
  input  logic                         best_improved_o,
  input  logic [9:0]                   best_index_o,
  input  logic signed [23:0]           best_fitness_o,
  input  logic [pfs_pkg::GenWidth-1:0] best_generation_o,
  output int                           pending_o,
  output int                           fail_count_o
);

  localparam int unsigned MaxPop = 1024;
  localparam logic signed [23:0] FitMaxPos = 24'sh7FFFFF;
  localparam logic [22:0] StdDevMax = 23'h7FFFFF;

  typedef struct packed {
    logic signed [23:0] min_fit;
    logic signed [23:0] max_fit;
    logic signed [23:0] mean_fit;
    logic [22:0]        std_dev;
    logic               improved;
    logic [9:0]         best_idx;
    logic signed [23:0] best_fit;
    logic [15:0]        best_gen;
  } gen_summary_t;

  gen_summary_t summary_q[$];

  // Tracked copy of the block's statistics state.
  logic [10:0]        size_reg;
  logic signed [23:0] gen_min, gen_max;
  longint             gen_sum;
  logic [63:0]        gen_sum_sq;
  int unsigned        members;
  logic signed [23:0] best_fit;
  logic [9:0]         best_idx;
  logic [15:0]        best_gen;
  logic               improved;

  assign pending_o = summary_q.size();

  // Bitwise integer square root; arguments stay below 2^58.
  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] root, trial;
    root = '0;
    for (int b = 29; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= val) root = trial;
    end
    return root;
  endfunction

  function automatic int unsigned active_size(input logic [10:0] sz);
    if (sz == 0) return 1;
    if (sz > MaxPop) return MaxPop;
    return sz;
  endfunction

  // Folds one member into the generation and returns 1 when it closes it.
  function automatic bit fold_member(input logic signed [23:0] fit, input logic [15:0] gen,
                                     output gen_summary_t s);
    longint      mean, fv, mag;
    logic [63:0] q, msq, diff, root;
    fv = fit;
    mag = (fv < 0) ? -fv : fv;
    if (members == 0) begin
      gen_min = fit;
      gen_max = fit;
    end else begin
      if (fit > gen_max) gen_max = fit;
      if (fit < gen_min) gen_min = fit;
    end
    gen_sum += fv;
    gen_sum_sq += 64'(mag * mag);
    if (fit < best_fit) begin
      best_fit = fit;
      best_idx = members[9:0];
      best_gen = gen;
      improved = 1'b1;
    end
    members++;
    if (members < active_size(size_reg)) return 0;
    mean = gen_sum / longint'(members);
    q = gen_sum_sq / 64'(members);
    mag = (mean < 0) ? -mean : mean;
    msq = 64'(mag * mag);
    diff = (q >= msq) ? q - msq : msq - q;
    root = int_sqrt(diff);
    s.min_fit = gen_min;
    s.max_fit = gen_max;
    s.mean_fit = mean[23:0];
    s.std_dev = (root > 64'(StdDevMax)) ? StdDevMax : root[22:0];
    s.improved = improved;
    s.best_idx = best_idx;
    s.best_fit = best_fit;
    s.best_gen = best_gen;
    gen_min = '0;
    gen_max = '0;
    gen_sum = 0;
    gen_sum_sq = '0;
    members = 0;
    improved = 1'b0;
    return 1;
  endfunction

  task automatic report(input string field, input longint exp_v, input longint act_v);
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, exp_v, act_v);
  endtask

  // Results are compared before the value of the same edge is folded in.
  always @(posedge clk_i or negedge rst_ni) begin
    gen_summary_t exp_s, new_s;
    bit bad;
    if (!rst_ni) begin
      summary_q.delete();
      fail_count_o = 0;
      size_reg = 11'd1024;
      gen_min = '0;
      gen_max = '0;
      gen_sum = 0;
      gen_sum_sq = '0;
      members = 0;
      best_fit = FitMaxPos;
      best_idx = '0;
      best_gen = '0;
      improved = 1'b0;
    end else begin
      if (result_valid_o) begin
        if (summary_q.size() == 0) begin
          $display("%0t: mismatch: result transfer with nothing expected", $time);
          fail_count_o++;
        end else begin
          exp_s = summary_q.pop_front();
          bad = 0;
          if (min_fitness_o !== exp_s.min_fit) begin
            report("min_fitness", exp_s.min_fit, min_fitness_o); bad = 1;
          end
          if (max_fitness_o !== exp_s.max_fit) begin
            report("max_fitness", exp_s.max_fit, max_fitness_o); bad = 1;
          end
          if (mean_fitness_o !== exp_s.mean_fit) begin
            report("mean_fitness", exp_s.mean_fit, mean_fitness_o); bad = 1;
          end
          if (std_dev_o !== exp_s.std_dev) begin
            report("std_dev", exp_s.std_dev, std_dev_o); bad = 1;
          end
          if (best_improved_o !== exp_s.improved) begin
            report("best_improved", exp_s.improved, best_improved_o); bad = 1;
          end
          if (best_index_o !== exp_s.best_idx) begin
            report("best_index", exp_s.best_idx, best_index_o); bad = 1;
          end
          if (best_fitness_o !== exp_s.best_fit) begin
            report("best_fitness", exp_s.best_fit, best_fitness_o); bad = 1;
          end
          if (best_generation_o !== exp_s.best_gen) begin
            report("best_generation", exp_s.best_gen, best_generation_o); bad = 1;
          end
          if (bad) fail_count_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) size_reg = cfg_data_i;
      if (start && !busy) begin
        if (fold_member(fitness_i, generation_i, new_s)) summary_q.push_back(new_s);
      end
    end
  end

endmodule

### verif/tb_population_fitness_statistics_core.sv
`timescale 1ns / 1ps
module tb_population_fitness_statistics_core;

  localparam logic signed [23:0] FitMaxPos = 24'sh7FFFFF;
  localparam logic signed [23:0] FitMaxNeg = 24'sh800000;
  // Pause after the last summary before a size write or the verdict.
  localparam int SettleCycles = 150;

  logic clk_i, rst_ni, start, busy;
  logic cfg_valid_i, cfg_ready_o;
  logic [pfs_pkg::CfgWidth-1:0] cfg_data_i;
  logic signed [23:0] fitness_i;
  logic [pfs_pkg::GenWidth-1:0] generation_i;
  logic result_valid_o, best_improved_o;
  logic signed [23:0] min_fitness_o, max_fitness_o, mean_fitness_o, best_fitness_o;
  logic [22:0] std_dev_o;
  logic [9:0] best_index_o;
  logic [pfs_pkg::GenWidth-1:0] best_generation_o;
  int pending, fail_count;

  int burst_left;
  bit no_gaps;
  int values_sent;

  population_fitness_statistics_core u_dut (.*);

  pfs_stats_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fitness_i, .generation_i, .result_valid_o, .min_fitness_o, .max_fitness_o,
    .mean_fitness_o, .std_dev_o, .best_improved_o, .best_index_o, .best_fitness_o,
    .best_generation_o, .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Waits for all summaries, then lets the divider and root settle.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Stops sending, then writes the size once nothing is in flight.
  task automatic write_size(input logic [10:0] sz);
    @(negedge clk_i);
    start = 1'b0;
    drain();
    cfg_data_i = sz;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One value transfer; start stays high across a burst.
  task automatic send_value(input logic signed [23:0] fit, input logic [15:0] gen);
    @(negedge clk_i);
    start = 1'b1;
    fitness_i = fit;
    generation_i = gen;
    do @(posedge clk_i); while (busy);
    values_sent++;
    if (--burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      if (!no_gaps) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end
    end
  endtask

  function automatic logic signed [23:0] rand_fitness();
    case ($urandom_range(0, 9))
      0: return FitMaxPos;
      1: return FitMaxNeg;
      2, 3: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
      default: return $signed(24'($urandom()));
    endcase
  endfunction

  initial begin
    int gen_no;
    int sz;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    fitness_i = '0;
    generation_i = '0;
    burst_left = 4;
    no_gaps = 0;
    values_sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: the largest value never beats the reset best; size lowered
    // mid-generation; size zero acts as one; equal minima keep the first.
    send_value(FitMaxPos, 16'hFFFF);
    send_value(FitMaxNeg, 16'h0000);
    send_value(FitMaxPos, 16'h8001);
    write_size(11'd2);
    send_value(24'sd0, 16'h1234);
    write_size(11'd0);
    send_value(FitMaxNeg, 16'h00FF);
    send_value(24'sd0, 16'h7F00);
    send_value(FitMaxPos, 16'h0001);
    write_size(11'd1);
    send_value(-24'sd1, 16'h0002);
    write_size(11'd3);
    send_value(24'sd5, 16'h0003);
    send_value(24'sd5, 16'h0003);
    send_value(24'sd5, 16'h0003);
    send_value(FitMaxPos, 16'hAAAA);
    send_value(FitMaxNeg, 16'h5555);
    send_value(FitMaxPos, 16'hAAAA);
    write_size(11'd4);
    send_value(FitMaxNeg, 16'h0004);
    send_value(FitMaxNeg, 16'h0004);
    send_value(FitMaxNeg, 16'h0004);
    send_value(FitMaxNeg, 16'h0004);

    // Random generations, mostly small, with a few stretches without gaps.
    // A full-size generation follows once 250 values have been sent in all.
    gen_no = 5;
    while (values_sent < 250) begin
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      no_gaps = ($urandom_range(0, 4) == 0);
      write_size(11'(sz));
      repeat (sz) send_value(rand_fitness(), ($urandom_range(0, 3) == 0) ?
                             16'($urandom()) : 16'(gen_no));
      // Now and then leave a partial generation open across the next write.
      if ($urandom_range(0, 9) == 0) send_value(rand_fitness(), 16'($urandom()));
      gen_no++;
    end

    // Oversized register saturates to the largest population.
    no_gaps = 0;
    write_size(11'h7FF);
    repeat (1024) send_value($signed(24'($urandom_range(0, 65535))) - 24'sd32768,
                             16'($urandom()));
    @(negedge clk_i);
    start = 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
